// ===== rtl/kuznyechik_block_cipher_top_defines.svh =====
// Assertion macros for the Kuznyechik block cipher.
// Included by the top level; no other dependencies.
`ifndef KUZNYECHIK_BLOCK_CIPHER_TOP_DEFINES_SVH
`define KUZNYECHIK_BLOCK_CIPHER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define KBC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kbc: same-cycle check failed");
// Next-cycle implication
`define KBC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kbc: next-cycle check failed");
`else
`define KBC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define KBC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/kbc_pkg.sv =====
// Types, constant tables and transform functions for the Kuznyechik cipher.
// No dependencies; used by kbc_round and the top level.
package kbc_pkg;

    localparam int WORD_W         = 64;
    localparam int NUM_ROUND_KEYS = 10;
    localparam int RK_AW          = $clog2(NUM_ROUND_KEYS);
    localparam int NUM_XSTEPS     = 32;
    localparam int XSTEP_W        = $clog2(NUM_XSTEPS);
    localparam int CFG_IDX_W      = 2;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // Key register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_W0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_W1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_W2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_W3 = CFG_IDX_W'(3);

    localparam logic [RK_AW-1:0]   RK_FIRST   = '0;
    localparam logic [RK_AW-1:0]   RK_SECOND  = RK_AW'(1);
    localparam logic [RK_AW-1:0]   RK_LAST    = RK_AW'(NUM_ROUND_KEYS - 1);
    localparam logic [XSTEP_W-1:0] XSTEP_LAST = XSTEP_W'(NUM_XSTEPS - 1);

    localparam logic [8:0] GF_POLY = 9'h1C3;

    // Byte 0 is the most significant byte of a block
    typedef logic [0:15][7:0]        t_blk;
    typedef logic [0:15][0:15][7:0]  t_mat;
    typedef logic [0:31][0:15][7:0]  t_ctab;
    typedef logic [0:255][7:0]       t_sbox;

    typedef struct packed {
        logic              op;
        logic [WORD_W-1:0] block_high;
        logic [WORD_W-1:0] block_low;
    } t_in;

    typedef struct packed {
        logic [WORD_W-1:0] result_high;
        logic [WORD_W-1:0] result_low;
    } t_out;

    localparam t_blk LCOEF = {
        8'h94, 8'h20, 8'h85, 8'h10, 8'hC2, 8'hC0, 8'h01, 8'hFB,
        8'h01, 8'hC0, 8'hC2, 8'h10, 8'h85, 8'h20, 8'h94, 8'h01
    };

    localparam t_sbox SBOX = {
        8'hFC, 8'hEE, 8'hDD, 8'h11, 8'hCF, 8'h6E, 8'h31, 8'h16,
        8'hFB, 8'hC4, 8'hFA, 8'hDA, 8'h23, 8'hC5, 8'h04, 8'h4D,
        8'hE9, 8'h77, 8'hF0, 8'hDB, 8'h93, 8'h2E, 8'h99, 8'hBA,
        8'h17, 8'h36, 8'hF1, 8'hBB, 8'h14, 8'hCD, 8'h5F, 8'hC1,
        8'hF9, 8'h18, 8'h65, 8'h5A, 8'hE2, 8'h5C, 8'hEF, 8'h21,
        8'h81, 8'h1C, 8'h3C, 8'h42, 8'h8B, 8'h01, 8'h8E, 8'h4F,
        8'h05, 8'h84, 8'h02, 8'hAE, 8'hE3, 8'h6A, 8'h8F, 8'hA0,
        8'h06, 8'h0B, 8'hED, 8'h98, 8'h7F, 8'hD4, 8'hD3, 8'h1F,
        8'hEB, 8'h34, 8'h2C, 8'h51, 8'hEA, 8'hC8, 8'h48, 8'hAB,
        8'hF2, 8'h2A, 8'h68, 8'hA2, 8'hFD, 8'h3A, 8'hCE, 8'hCC,
        8'hB5, 8'h70, 8'h0E, 8'h56, 8'h08, 8'h0C, 8'h76, 8'h12,
        8'hBF, 8'h72, 8'h13, 8'h47, 8'h9C, 8'hB7, 8'h5D, 8'h87,
        8'h15, 8'hA1, 8'h96, 8'h29, 8'h10, 8'h7B, 8'h9A, 8'hC7,
        8'hF3, 8'h91, 8'h78, 8'h6F, 8'h9D, 8'h9E, 8'hB2, 8'hB1,
        8'h32, 8'h75, 8'h19, 8'h3D, 8'hFF, 8'h35, 8'h8A, 8'h7E,
        8'h6D, 8'h54, 8'hC6, 8'h80, 8'hC3, 8'hBD, 8'h0D, 8'h57,
        8'hDF, 8'hF5, 8'h24, 8'hA9, 8'h3E, 8'hA8, 8'h43, 8'hC9,
        8'hD7, 8'h79, 8'hD6, 8'hF6, 8'h7C, 8'h22, 8'hB9, 8'h03,
        8'hE0, 8'h0F, 8'hEC, 8'hDE, 8'h7A, 8'h94, 8'hB0, 8'hBC,
        8'hDC, 8'hE8, 8'h28, 8'h50, 8'h4E, 8'h33, 8'h0A, 8'h4A,
        8'hA7, 8'h97, 8'h60, 8'h73, 8'h1E, 8'h00, 8'h62, 8'h44,
        8'h1A, 8'hB8, 8'h38, 8'h82, 8'h64, 8'h9F, 8'h26, 8'h41,
        8'hAD, 8'h45, 8'h46, 8'h92, 8'h27, 8'h5E, 8'h55, 8'h2F,
        8'h8C, 8'hA3, 8'hA5, 8'h7D, 8'h69, 8'hD5, 8'h95, 8'h3B,
        8'h07, 8'h58, 8'hB3, 8'h40, 8'h86, 8'hAC, 8'h1D, 8'hF7,
        8'h30, 8'h37, 8'h6B, 8'hE4, 8'h88, 8'hD9, 8'hE7, 8'h89,
        8'hE1, 8'h1B, 8'h83, 8'h49, 8'h4C, 8'h3F, 8'hF8, 8'hFE,
        8'h8D, 8'h53, 8'hAA, 8'h90, 8'hCA, 8'hD8, 8'h85, 8'h61,
        8'h20, 8'h71, 8'h67, 8'hA4, 8'h2D, 8'h2B, 8'h09, 8'h5B,
        8'hCB, 8'h9B, 8'h25, 8'hD0, 8'hBE, 8'hE5, 8'h6C, 8'h52,
        8'h59, 8'hA6, 8'h74, 8'hD2, 8'hE6, 8'hF4, 8'hB4, 8'hC0,
        8'hD1, 8'h66, 8'hAF, 8'hC2, 8'h39, 8'h4B, 8'h63, 8'hB6
    };

    // GF(2^8) product modulo x^8+x^7+x^6+x+1
    function automatic logic [7:0] f_gf_mul(logic [7:0] a, logic [7:0] b);
        logic [8:0] x;
        logic [7:0] p;
        x = {1'b0, a};
        p = '0;
        for (int n = 0; n < 8; n++) begin
            if (b[n]) p ^= x[7:0];
            x = {x[7:0], 1'b0};
            if (x[8]) x ^= GF_POLY;
        end
        return p;
    endfunction

    // One forward LFSR clock: shift toward byte 15, feedback into byte 0
    function automatic t_blk f_lin_clk_fwd(t_blk s);
        t_blk       o;
        logic [7:0] acc;
        acc = s[15];
        for (int i = 0; i < 15; i++) begin
            o[i + 1] = s[i];
            acc ^= f_gf_mul(s[i], LCOEF[i]);
        end
        o[0] = acc;
        return o;
    endfunction

    // One inverse LFSR clock: shift toward byte 0, feedback into byte 15
    function automatic t_blk f_lin_clk_inv(t_blk s);
        t_blk       o;
        logic [7:0] acc;
        acc = s[0];
        for (int i = 0; i < 15; i++) begin
            o[i] = s[i + 1];
            acc ^= f_gf_mul(s[i + 1], LCOEF[i]);
        end
        o[15] = acc;
        return o;
    endfunction

    // Full transform of sixteen LFSR steps, elaboration use only
    function automatic t_blk f_lin_full(t_blk s, logic inv);
        t_blk v;
        v = s;
        for (int r = 0; r < 16; r++) begin
            v = inv ? f_lin_clk_inv(v) : f_lin_clk_fwd(v);
        end
        return v;
    endfunction

    // Column i holds the transform of the unit vector at byte i
    function automatic t_mat f_lin_matrix(logic inv);
        t_mat m;
        t_blk e;
        for (int i = 0; i < 16; i++) begin
            e    = '0;
            e[i] = 8'h01;
            m[i] = f_lin_full(e, inv);
        end
        return m;
    endfunction

    // Feistel constants C(1)..C(32)
    function automatic t_ctab f_xconst();
        t_ctab tab;
        t_blk  c;
        for (int i = 0; i < NUM_XSTEPS; i++) begin
            c      = '0;
            c[15]  = 8'(i + 1);
            tab[i] = f_lin_full(c, 1'b0);
        end
        return tab;
    endfunction

    function automatic t_sbox f_sbox_inverse();
        t_sbox inv;
        for (int i = 0; i < 256; i++) begin
            inv[SBOX[i]] = 8'(i);
        end
        return inv;
    endfunction

    localparam t_mat  LFWD_MAT = f_lin_matrix(1'b0);
    localparam t_mat  LINV_MAT = f_lin_matrix(1'b1);
    localparam t_ctab XCONST   = f_xconst();
    localparam t_sbox SBOX_INV = f_sbox_inverse();

    // Linear layer as a constant GF(2^8) matrix product
    function automatic t_blk f_lin_apply(t_mat m, t_blk s);
        t_blk o;
        o = '0;
        for (int j = 0; j < 16; j++) begin
            for (int i = 0; i < 16; i++) begin
                o[j] ^= f_gf_mul(s[i], m[i][j]);
            end
        end
        return o;
    endfunction

    function automatic t_blk f_sub(t_blk s, t_sbox tab);
        t_blk o;
        for (int j = 0; j < 16; j++) begin
            o[j] = tab[s[j]];
        end
        return o;
    endfunction

endpackage

// ===== rtl/kuznyechik_block_cipher_top.sv =====
// Kuznyechik block cipher, one round per cycle from a round key RAM.
// The done strobe is registered from the last round; a new item can be accepted during the last round.
// After a key write the first item first runs the round key expansion.
// Synchronous active-low reset clears control and key words; the round key RAM is
// rebuilt on the first item, the receiver cannot stall results.
`include "kuznyechik_block_cipher_top_defines.svh"
module kuznyechik_block_cipher_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  kbc_pkg::t_in                        i_in,
    output logic                                busy,
    output logic                                o_done,
    output kbc_pkg::t_out                       o_out,
    input  logic                                i_cfg_we,
    input  logic [kbc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [kbc_pkg::WORD_W-1:0]          i_cfg_data
);
    import kbc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_XSTEP = 3'b010,
        S_RUN   = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic [WORD_W-1:0]    r_key [2**CFG_IDX_W];
    logic                 r_keys_ready;
    logic [RK_AW-1:0]     r_n, n_n;
    logic [XSTEP_W-1:0]   r_xstep, n_xstep;
    logic                 r_op;
    t_blk                 r_s, r_a, r_b;
    t_out                 r_res;
    logic                 r_done;

    logic                 w_accept, w_xlast, w_rlast;
    logic [WORD_W-1:0]    w_rk_hi, w_rk_lo;
    t_blk                 w_key, w_key01, w_key23;
    t_blk                 w_x, w_mix, w_fwd, w_inv, w_feistel;
    t_blk                 w_run_next, w_result;
    logic [RK_AW-1:0]     w_raddr, w_waddr, w_pair;
    logic                 w_we;
    t_blk                 w_wdata;

    assign w_xlast  = (r_state == S_XSTEP) && (r_xstep == XSTEP_LAST);
    assign w_rlast  = (r_state == S_RUN) && (r_n == RK_LAST);
    assign busy     = !((r_state == S_IDLE) || w_rlast);
    assign w_accept = start && !busy;

    assign w_key   = {w_rk_hi, w_rk_lo};
    assign w_key01 = {r_key[CFG_KEY_W0], r_key[CFG_KEY_W1]};
    assign w_key23 = {r_key[CFG_KEY_W2], r_key[CFG_KEY_W3]};

    // Share the forward unit between rounds and key expansion
    assign w_x       = (r_state == S_RUN) ? r_s : r_a;
    assign w_mix     = (r_state == S_RUN) ? w_key : XCONST[r_xstep];
    assign w_feistel = w_fwd ^ r_b;

    kbc_round u_round (
        .i_x   (w_x),
        .i_mix (w_mix),
        .i_key (w_key),
        .o_fwd (w_fwd),
        .o_inv (w_inv)
    );

    // Even key slot of the current group of eight expansion steps
    assign w_pair = {1'b0, r_xstep[XSTEP_W-1:XSTEP_W-2], 1'b0} + RK_AW'(2);

    // Round key read: fetch in the cycle before the key is used
    always_comb begin
        w_raddr = RK_FIRST;
        if (w_accept) begin
            w_raddr = (i_in.op == OP_DECRYPT) ? RK_LAST : RK_FIRST;
        end else if ((r_state == S_RUN) && (r_n != RK_LAST)) begin
            w_raddr = (r_op == OP_DECRYPT) ? (RK_LAST - r_n - RK_SECOND) : (r_n + RK_SECOND);
        end else if (w_xlast) begin
            w_raddr = (r_op == OP_DECRYPT) ? RK_LAST : RK_FIRST;
        end
    end

    // Round key write: the expansion steps never write a slot read in the same cycle
    always_comb begin
        w_we    = 1'b0;
        w_waddr = RK_FIRST;
        w_wdata = w_feistel;
        if (w_accept && !r_keys_ready) begin
            w_we    = 1'b1;
            w_wdata = w_key01;
        end else if (r_state == S_XSTEP) begin
            if (r_xstep == '0) begin
                w_we    = 1'b1;
                w_waddr = RK_SECOND;
                w_wdata = r_b;
            end else if (r_xstep[2:0] == 3'd7) begin
                w_we    = 1'b1;
                w_waddr = w_pair;
            end else if (r_xstep[2:0] == 3'd6) begin
                w_we    = 1'b1;
                w_waddr = w_pair + RK_SECOND;
            end
        end
    end

    kbc_ram #(.WIDTH(WORD_W), .DEPTH(NUM_ROUND_KEYS)) u_rk_hi (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata[0:7]),
        .i_raddr (w_raddr),
        .o_rdata (w_rk_hi)
    );

    kbc_ram #(.WIDTH(WORD_W), .DEPTH(NUM_ROUND_KEYS)) u_rk_lo (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata[8:15]),
        .i_raddr (w_raddr),
        .o_rdata (w_rk_lo)
    );

    // Round update and final value per direction
    always_comb begin
        if (r_op == OP_ENCRYPT) begin
            w_run_next = w_fwd;
            w_result   = r_s ^ w_key;
        end else begin
            w_run_next = (r_n == RK_FIRST) ? (r_s ^ w_key) : w_inv;
            w_result   = w_inv;
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_xstep = r_xstep;
        unique case (r_state)
            S_IDLE: begin
            end
            S_XSTEP: begin
                n_xstep = r_xstep + XSTEP_W'(1);
                if (w_xlast) begin
                    n_state = S_RUN;
                    n_n     = RK_FIRST;
                end
            end
            S_RUN: begin
                n_n = r_n + RK_SECOND;
                if (w_rlast) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (w_accept) begin
            n_state = r_keys_ready ? S_RUN : S_XSTEP;
            n_n     = RK_FIRST;
            n_xstep = '0;
        end
    end

    // Control and key words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_n          <= RK_FIRST;
            r_xstep      <= '0;
            r_keys_ready <= 1'b0;
            r_done       <= 1'b0;
            for (int i = 0; i < 2**CFG_IDX_W; i++) r_key[i] <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_xstep <= n_xstep;
            r_done  <= w_rlast;
            if (i_cfg_we) begin
                r_key[i_cfg_idx] <= i_cfg_data;
                r_keys_ready     <= 1'b0;
            end else if (w_xlast) begin
                r_keys_ready <= 1'b1;
            end
        end
    end

    // Block state, Feistel halves and result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op <= i_in.op;
            r_s  <= {i_in.block_high, i_in.block_low};
            r_a  <= w_key01;
            r_b  <= w_key23;
        end else begin
            if (r_state == S_RUN) r_s <= w_run_next;
            if (r_state == S_XSTEP) begin
                r_a <= w_feistel;
                r_b <= r_a;
            end
        end
        if (w_rlast) begin
            r_res.result_high <= w_result[0:7];
            r_res.result_low  <= w_result[8:15];
        end
    end

    assign o_done = r_done;
    assign o_out  = r_res;

    `KBC_ASSERT_NXT(a_xpand_then_run, i_clk, i_rst_n, w_xlast,
        r_state == S_RUN && r_n == RK_FIRST)
    `KBC_ASSERT_NXT(a_last_round_done, i_clk, i_rst_n, w_rlast, o_done)
    `KBC_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, w_accept,
        (r_state == S_RUN && r_n == RK_FIRST) || (r_state == S_XSTEP && r_xstep == '0))

endmodule

// ===== rtl/kbc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module kbc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 10,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read; the read data is registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/kbc_round.sv =====
// Round datapath: forward S-box and linear layer, and the inverse round.
// Depends on kbc_pkg for the tables and transform functions.
module kbc_round (
    input  kbc_pkg::t_blk i_x,
    input  kbc_pkg::t_blk i_mix,
    input  kbc_pkg::t_blk i_key,
    output kbc_pkg::t_blk o_fwd,
    output kbc_pkg::t_blk o_inv
);
    import kbc_pkg::*;

    // Forward: L(S(x ^ mix)), mix is a round key or a Feistel constant
    assign o_fwd = f_lin_apply(LFWD_MAT, f_sub(i_x ^ i_mix, SBOX));

    // Inverse: S^-1(L^-1(x)) ^ key
    assign o_inv = f_sub(f_lin_apply(LINV_MAT, i_x), SBOX_INV) ^ i_key;

endmodule
